>>> rtl/assert_macros.svh
// Assertion helpers for the heap RTL.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BMHPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bmhpq_pkg.sv
`default_nettype none
package bmhpq_pkg;

  localparam int DEPTH    = 256;
  localparam int TAG_BITS = 16;
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int STAT_W   = 3;

  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CHILD_W  = CNT_W + 1;
  localparam int CMP_W    = (POS_W > CHILD_W) ? POS_W : CHILD_W;
  localparam int ENT_W    = KEY_W + TAG_BITS;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INC     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEC     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIR    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_BITS-1:0]     tag;
  } entry_t;

  typedef struct packed {
    logic                    valid;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] min_key;
    logic [TAG_BITS-1:0]     min_tag;
    logic [CNT_W-1:0]        entry_count;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/bmhpq_ram.sv
`default_nettype none
module bmhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/bmhpq_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module bmhpq_ctrl (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [bmhpq_pkg::KIND_W-1:0]          req_kind,
  input  wire logic [bmhpq_pkg::POS_W-1:0]           req_pos,
  input  wire logic signed [bmhpq_pkg::KEY_W-1:0]    req_key,
  input  wire logic [bmhpq_pkg::TAG_BITS-1:0]        req_tag,
  output logic                                       busy,
  output logic                                       ram_we,
  output logic [bmhpq_pkg::ADDR_W-1:0]               ram_waddr,
  output logic [bmhpq_pkg::ENT_W-1:0]                ram_wdata,
  output logic [bmhpq_pkg::ADDR_W-1:0]               ram_raddr,
  input  wire logic [bmhpq_pkg::ENT_W-1:0]           ram_rdata,
  output bmhpq_pkg::result_t                         res
);
  import bmhpq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_LAST  = 4'd3;
  localparam logic [3:0] S_POS   = 4'd4;
  localparam logic [3:0] S_UP    = 4'd5;
  localparam logic [3:0] S_UPC   = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_DNL   = 4'd8;
  localparam logic [3:0] S_DNR   = 4'd9;

  // heap position (1-based) to RAM address
  function automatic logic [ADDR_W-1:0] slot(input logic [CHILD_W-1:0] p);
    logic [CHILD_W-1:0] a;
    a = p - 1'b1;
    return a[ADDR_W-1:0];
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        hole_r, hole_nxt;
  entry_t                  mov_r, mov_nxt;
  entry_t                  left_r, left_nxt;
  logic                    moved_r, moved_nxt;
  logic signed [KEY_W-1:0] min_key_r, min_key_nxt;
  logic [TAG_BITS-1:0]     min_tag_r, min_tag_nxt;

  entry_t             rd;
  logic               fin;
  logic [STAT_W-1:0]  fin_status;
  logic               pos_bad;
  logic [CHILD_W-1:0] hole_ext;
  logic [CHILD_W-1:0] lchild;
  logic [CHILD_W-1:0] rchild;
  logic [CHILD_W-1:0] count_ext;

  assign rd        = entry_t'(ram_rdata);
  assign count_ext = CHILD_W'(count_r);
  assign hole_ext  = CHILD_W'(hole_r);
  assign lchild    = {hole_r, 1'b0};
  assign rchild    = lchild + 1'b1;
  assign pos_bad   = (pos_r == '0) || (CMP_W'(pos_r) > CMP_W'(count_r));
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    tag_nxt     = tag_r;
    count_nxt   = count_r;
    hole_nxt    = hole_r;
    mov_nxt     = mov_r;
    left_nxt    = left_r;
    moved_nxt   = moved_r;
    min_key_nxt = min_key_r;
    min_tag_nxt = min_tag_r;
    fin         = 1'b0;
    fin_status  = ST_OK;
    ram_we      = 1'b0;
    ram_waddr   = slot(hole_ext);
    ram_wdata   = mov_r;
    ram_raddr   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt    = req_kind;
          pos_nxt     = req_pos;
          key_nxt     = req_key;
          tag_nxt     = req_tag;
          min_key_nxt = '0;
          min_tag_nxt = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        case (kind_r)
          KIND_INSERT: begin
            if (count_r == CNT_FULL) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              hole_nxt  = count_r + 1'b1;
              mov_nxt   = '{key: key_r, tag: tag_r};
              moved_nxt = 1'b0;
              state_nxt = S_UP;
            end
          end
          KIND_PEEK, KIND_EXTRACT: begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              ram_raddr = slot(CHILD_W'(1));
              state_nxt = S_ROOT;
            end
          end
          KIND_INC, KIND_DEC: begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else if (pos_bad) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else begin
              ram_raddr = slot(CHILD_W'(pos_r));
              state_nxt = S_POS;
            end
          end
          KIND_DELETE: begin
            if (pos_bad) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else begin
              ram_raddr = slot(count_ext);
              state_nxt = S_LAST;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_ROOT: begin
        min_key_nxt = rd.key;
        min_tag_nxt = rd.tag;
        if (kind_r == KIND_PEEK) begin
          fin = 1'b1;
        end else begin
          ram_raddr = slot(count_ext);
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // last entry fills the hole; drop it outright when it is the hole
        mov_nxt   = rd;
        count_nxt = count_r - 1'b1;
        moved_nxt = 1'b0;
        hole_nxt  = (kind_r == KIND_EXTRACT) ? CNT_W'(1) : CNT_W'(pos_r);
        if (hole_nxt == count_r) begin
          fin = 1'b1;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_POS: begin
        if ((kind_r == KIND_INC && rd.key > key_r) ||
            (kind_r == KIND_DEC && rd.key < key_r)) begin
          fin        = 1'b1;
          fin_status = ST_DIR;
        end else begin
          mov_nxt   = '{key: key_r, tag: rd.tag};
          hole_nxt  = CNT_W'(pos_r);
          moved_nxt = 1'b0;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (hole_r == CNT_W'(1)) begin
          if (moved_r) begin
            ram_we = 1'b1;
            fin    = 1'b1;
          end else begin
            state_nxt = S_DN;
          end
        end else begin
          ram_raddr = slot(hole_ext >> 1);
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        if (mov_r.key < rd.key) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          hole_nxt  = hole_r >> 1;
          moved_nxt = 1'b1;
          state_nxt = S_UP;
        end else if (moved_r) begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_DN: begin
        if (lchild > count_ext) begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end else begin
          ram_raddr = slot(lchild);
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        left_nxt = rd;
        if (rchild <= count_ext) begin
          ram_raddr = slot(rchild);
          state_nxt = S_DNR;
        end else if (rd.key < mov_r.key) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          hole_nxt  = lchild[CNT_W-1:0];
          state_nxt = S_DN;
        end else begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end
      end
      S_DNR: begin
        // left wins ties between children
        if (left_r.key < mov_r.key && !(rd.key < left_r.key)) begin
          ram_we    = 1'b1;
          ram_wdata = left_r;
          hole_nxt  = lchild[CNT_W-1:0];
          state_nxt = S_DN;
        end else if (rd.key < mov_r.key) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          hole_nxt  = rchild[CNT_W-1:0];
          state_nxt = S_DN;
        end else begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end

    res.valid       = fin;
    res.status      = fin_status;
    res.min_key     = (fin_status == ST_OK) ? min_key_nxt : '0;
    res.min_tag     = (fin_status == ST_OK) ? min_tag_nxt : '0;
    res.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    pos_r     <= pos_nxt;
    key_r     <= key_nxt;
    tag_r     <= tag_nxt;
    hole_r    <= hole_nxt;
    mov_r     <= mov_nxt;
    left_r    <= left_nxt;
    moved_r   <= moved_nxt;
    min_key_r <= min_key_nxt;
    min_tag_r <= min_tag_nxt;
  end

  `BMHPQ_ASSERT_NXT(a_accept_busy, start && (state_r == S_IDLE), state_r != S_IDLE, "accepted request did not start")
  `BMHPQ_ASSERT_NXT(a_done_idle, res.valid, state_r == S_IDLE, "sequencer did not return to idle")
  `BMHPQ_ASSERT_NXT(a_count_hold, (state_r == S_IDLE) && !start, $stable(count_r), "count moved while idle")
  `BMHPQ_ASSERT_IMP(a_full_count, res.valid && (res.status == ST_FULL), count_r == CNT_FULL, "full reported below capacity")
  `BMHPQ_ASSERT_IMP(a_write_busy, ram_we, state_r != S_IDLE, "entry write while idle")

endmodule
`default_nettype wire

>>> rtl/binary_min_heap_priority_queue_core.sv
`default_nettype none
// One request at a time: the next one is taken as the result goes out. The one
//   RAM read port paces the sifts, reading the parent at each level up and up
//   to both children at each level down.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are not cleared.
// The receiver cannot stall: out_valid pulses for exactly one cycle.
module binary_min_heap_priority_queue_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [bmhpq_pkg::KIND_W-1:0]          in_kind,
  input  wire logic [bmhpq_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [bmhpq_pkg::KEY_W-1:0]    in_new_key,
  input  wire logic [bmhpq_pkg::TAG_BITS-1:0]        in_entry_tag,
  output logic                                       out_valid,
  output logic [bmhpq_pkg::STAT_W-1:0]               out_status,
  output logic signed [bmhpq_pkg::KEY_W-1:0]         out_min_key,
  output logic [bmhpq_pkg::TAG_BITS-1:0]             out_min_tag,
  output logic [bmhpq_pkg::CNT_W-1:0]                out_entry_count
);
  import bmhpq_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  result_t           res;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic signed [KEY_W-1:0] out_min_key_r;
  logic [TAG_BITS-1:0]     out_min_tag_r;
  logic [CNT_W-1:0]        out_entry_count_r;

  // Key and tag of each entry live side by side in one word; heap position p
  // sits at address p-1. Each sift step reads a neighbour of the hole before it
  // writes the hole, and the sequencer never has two accesses to one entry in flight.
  bmhpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: checks the request, then reads the root or walks the hole up or down the tree.
  bmhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_kind  (in_kind),
    .req_pos   (in_position),
    .req_key   (in_new_key),
    .req_tag   (in_entry_tag),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  // Hold the result for its one-cycle strobe; a new request may be taken
  // in that same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r      <= res.status;
      out_min_key_r     <= res.min_key;
      out_min_tag_r     <= res.min_tag;
      out_entry_count_r <= res.entry_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_min_key     = out_min_key_r;
  assign out_min_tag     = out_min_tag_r;
  assign out_entry_count = out_entry_count_r;

endmodule
`default_nettype wire
